>>> src/cpc_pkg.sv
`default_nettype none
package cpc_pkg;

  localparam int COORD_BITS = 12;
  localparam int CLIP_SLOTS = 8;
  localparam int OUT_CAP    = 20;
  localparam int CFG_W      = 48;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = 4;

  // Widths of the exact integer line arithmetic.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int K_W    = 2 * COORD_BITS + 2;
  localparam int DET_W  = 2 * COORD_BITS + 3;
  localparam int NUM_W  = 3 * COORD_BITS + 4;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  typedef enum logic [IDX_W-1:0] {
    REG_COUNT = 3'd0,
    REG_PAIR0 = 3'd1,
    REG_PAIR1 = 3'd2,
    REG_PAIR2 = 3'd3,
    REG_PAIR3 = 3'd4
  } reg_idx_e;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // One request between clipping stages: a vertex or an end-of-item mark.
  typedef struct packed {
    pt_t  pt;
    logic is_end;
    logic last;
  } tok_t;

  typedef struct packed {
    pt_t  b;
    pt_t  f;
    logic en;
  } edge_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   vertex_last;
  } vtx_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   has_vertex;
    logic   out_last;
    logic   rejected;
  } res_t;

  function automatic logic signed [DIFF_W-1:0] dif(coord_t u, coord_t v);
    return $signed({1'b0, u}) - $signed({1'b0, v});
  endfunction

  function automatic logic signed [K_W-1:0] ext_d(logic signed [DIFF_W-1:0] d);
    return K_W'(d);
  endfunction

  function automatic logic signed [K_W-1:0] ext_c(coord_t c);
    return $signed(K_W'(c));
  endfunction

  function automatic logic signed [DET_W-1:0] cross3(pt_t a, pt_t b, pt_t c);
    logic signed [DET_W-1:0] p0;
    logic signed [DET_W-1:0] p1;
    p0 = dif(b.x, a.x) * dif(c.y, b.y);
    p1 = dif(b.y, a.y) * dif(c.x, b.x);
    return p0 - p1;
  endfunction

  // Truncated quotient magnitude and sign to a pixel coordinate.
  function automatic coord_t clamp_q(logic neg, logic [NUM_W-1:0] q);
    coord_t r;
    if (q == '0) begin
      r = '0;
    end else if (neg) begin
      r = '0;
    end else if (q > NUM_W'(COORD_MAX)) begin
      r = '1;
    end else begin
      r = q[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/cpc_div.sv
`default_nettype none
module cpc_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [cpc_pkg::NUM_W-1:0]    num_i,
  input  wire logic signed [cpc_pkg::DET_W-1:0]    den_i,
  output logic                                     done_o,
  output logic                                     neg_o,
  output logic [cpc_pkg::NUM_W-1:0]                quo_o
);

  localparam int NW = cpc_pkg::NUM_W;
  localparam int DW = cpc_pkg::DET_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] a_q;
  logic [DW-1:0] r_q;
  logic [DW-1:0] d_q;
  logic          neg_q;

  logic [DW:0]   trial;
  logic [DW:0]   sub;
  logic          ge;
  logic [DW-1:0] r_d;

  always_comb begin
    trial = {r_q, a_q[NW-1]};
    sub   = trial - {1'b0, d_q};
    ge    = trial >= {1'b0, d_q};
    r_d   = ge ? sub[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= num_i[NW-1] ? $unsigned(-num_i) : $unsigned(num_i);
      d_q   <= den_i[DW-1] ? $unsigned(-den_i) : $unsigned(den_i);
      r_q   <= '0;
      neg_q <= num_i[NW-1] ^ den_i[DW-1];
    end else if (busy_q) begin
      a_q <= {a_q[NW-2:0], ge};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign neg_o  = neg_q;
  assign quo_o  = a_q;

endmodule
`default_nettype wire

>>> src/cpc_cell.sv
`default_nettype none
module cpc_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cpc_pkg::edge_t  edge_i,
  input  wire logic            clear_i,
  input  wire logic            in_vld_i,
  output logic                 in_rdy_o,
  input  wire cpc_pkg::tok_t   in_tok_i,
  output logic                 out_vld_o,
  input  wire logic            out_rdy_i,
  output cpc_pkg::tok_t        out_tok_o
);

  localparam int DIFF_W = cpc_pkg::DIFF_W;
  localparam int K_W    = cpc_pkg::K_W;
  localparam int DET_W  = cpc_pkg::DET_W;
  localparam int NUM_W  = cpc_pkg::NUM_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIDE_E, ST_SIDE_S, ST_K1, ST_K2, ST_DET, ST_NUMX, ST_NUMY,
    ST_DIVX, ST_DIVY, ST_PUSH_X, ST_PUSH_E, ST_FWD
  } state_e;

  state_e state_q;
  logic   seen_q;
  logic   fwd_q;
  logic   e_in_q;
  logic   out_vld_q;

  cpc_pkg::pt_t  first_q, prev_q, s_q, e_q, crx_q;
  cpc_pkg::tok_t tok_q, out_tok_q;
  logic signed [K_W-1:0]   k1_q, k2_q;
  logic signed [DET_W-1:0] det_q;
  logic signed [NUM_W-1:0] numx_q, numy_q;

  logic can_push;
  logic s_in;

  logic signed [DIFF_W-1:0] ln1_a, ln1_c, ln2_a, ln2_c;
  logic signed [DIFF_W-1:0] op_a0, op_a1;
  logic signed [K_W-1:0]    op_b0, op_b1;
  logic                     op_sub;
  logic signed [NUM_W-1:0]  prod0, prod1, mac;

  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic                    div_done;
  logic                    div_neg;
  logic [NUM_W-1:0]        div_quo;

  assign can_push = !out_vld_q || out_rdy_i;
  assign in_rdy_o = (state_q == ST_IDLE);

  // Shared multiply-accumulate; operands follow the step in progress.
  always_comb begin
    ln1_a  = cpc_pkg::dif(e_q.y, s_q.y);
    ln1_c  = cpc_pkg::dif(s_q.x, e_q.x);
    ln2_a  = cpc_pkg::dif(edge_i.f.y, edge_i.b.y);
    ln2_c  = cpc_pkg::dif(edge_i.b.x, edge_i.f.x);
    op_a0  = '0;
    op_a1  = '0;
    op_b0  = '0;
    op_b1  = '0;
    op_sub = 1'b0;
    case (state_q)
      ST_SIDE_E: begin
        op_a0  = cpc_pkg::dif(e_q.x, edge_i.b.x);
        op_b0  = cpc_pkg::ext_d(cpc_pkg::dif(edge_i.f.y, edge_i.b.y));
        op_a1  = cpc_pkg::dif(e_q.y, edge_i.b.y);
        op_b1  = cpc_pkg::ext_d(cpc_pkg::dif(edge_i.f.x, edge_i.b.x));
        op_sub = 1'b1;
      end
      ST_SIDE_S: begin
        op_a0  = cpc_pkg::dif(s_q.x, edge_i.b.x);
        op_b0  = cpc_pkg::ext_d(cpc_pkg::dif(edge_i.f.y, edge_i.b.y));
        op_a1  = cpc_pkg::dif(s_q.y, edge_i.b.y);
        op_b1  = cpc_pkg::ext_d(cpc_pkg::dif(edge_i.f.x, edge_i.b.x));
        op_sub = 1'b1;
      end
      ST_K1: begin
        op_a0 = ln1_a;
        op_b0 = cpc_pkg::ext_c(s_q.x);
        op_a1 = ln1_c;
        op_b1 = cpc_pkg::ext_c(s_q.y);
      end
      ST_K2: begin
        op_a0 = ln2_a;
        op_b0 = cpc_pkg::ext_c(edge_i.b.x);
        op_a1 = ln2_c;
        op_b1 = cpc_pkg::ext_c(edge_i.b.y);
      end
      ST_DET: begin
        op_a0  = ln1_a;
        op_b0  = cpc_pkg::ext_d(ln2_c);
        op_a1  = ln2_a;
        op_b1  = cpc_pkg::ext_d(ln1_c);
        op_sub = 1'b1;
      end
      ST_NUMX: begin
        op_a0  = ln2_c;
        op_b0  = k1_q;
        op_a1  = ln1_c;
        op_b1  = k2_q;
        op_sub = 1'b1;
      end
      ST_NUMY: begin
        op_a0  = ln1_a;
        op_b0  = k2_q;
        op_a1  = ln2_a;
        op_b1  = k1_q;
        op_sub = 1'b1;
      end
      default: begin
      end
    endcase
    prod0 = op_a0 * op_b0;
    prod1 = op_a1 * op_b1;
    mac   = op_sub ? (prod0 - prod1) : (prod0 + prod1);
    s_in  = !mac[NUM_W-1];
  end

  assign div_start = ((state_q == ST_NUMY) && (det_q != '0)) ||
                     ((state_q == ST_DIVX) && div_done);
  assign div_num   = (state_q == ST_DIVX) ? numy_q : numx_q;

  cpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (det_q),
    .done_o  (div_done),
    .neg_o   (div_neg),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seen_q    <= 1'b0;
      fwd_q     <= 1'b0;
      e_in_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_vld_i) begin
            if (!edge_i.en) begin
              state_q <= ST_FWD;
            end else if (in_tok_i.is_end) begin
              if (in_tok_i.last && seen_q) begin
                // close the polygon: previous vertex back to the first
                seen_q  <= 1'b0;
                fwd_q   <= 1'b1;
                state_q <= ST_SIDE_E;
              end else begin
                state_q <= ST_FWD;
              end
            end else if (!seen_q) begin
              seen_q <= 1'b1;
            end else begin
              fwd_q   <= 1'b0;
              state_q <= ST_SIDE_E;
            end
          end
        end
        ST_SIDE_E: begin
          e_in_q  <= !mac[NUM_W-1];
          state_q <= ST_SIDE_S;
        end
        ST_SIDE_S: begin
          if (e_in_q != s_in) begin
            state_q <= ST_K1;
          end else if (e_in_q) begin
            state_q <= ST_PUSH_E;
          end else if (fwd_q) begin
            state_q <= ST_FWD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_K1:   state_q <= ST_K2;
        ST_K2:   state_q <= ST_DET;
        ST_DET:  state_q <= ST_NUMX;
        ST_NUMX: state_q <= ST_NUMY;
        ST_NUMY: begin
          state_q <= (det_q == '0) ? ST_PUSH_X : ST_DIVX;
        end
        ST_DIVX: begin
          if (div_done) begin
            state_q <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            state_q <= ST_PUSH_X;
          end
        end
        ST_PUSH_X: begin
          if (can_push) begin
            out_vld_q <= 1'b1;
            if (e_in_q) begin
              state_q <= ST_PUSH_E;
            end else if (fwd_q) begin
              state_q <= ST_FWD;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_PUSH_E: begin
          if (can_push) begin
            out_vld_q <= 1'b1;
            state_q   <= fwd_q ? ST_FWD : ST_IDLE;
          end
        end
        ST_FWD: begin
          if (can_push) begin
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (clear_i) begin
        seen_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_vld_i) begin
          tok_q <= in_tok_i;
          if (edge_i.en && !in_tok_i.is_end) begin
            if (!seen_q) begin
              first_q <= in_tok_i.pt;
            end else begin
              s_q <= prev_q;
              e_q <= in_tok_i.pt;
            end
            prev_q <= in_tok_i.pt;
          end else if (edge_i.en && in_tok_i.last && seen_q) begin
            s_q <= prev_q;
            e_q <= first_q;
          end
        end
      end
      ST_K1:   k1_q   <= mac[K_W-1:0];
      ST_K2:   k2_q   <= mac[K_W-1:0];
      ST_DET:  det_q  <= mac[DET_W-1:0];
      ST_NUMX: numx_q <= mac;
      ST_NUMY: begin
        numy_q <= mac;
        if (det_q == '0) begin
          crx_q <= '0;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          crx_q.x <= cpc_pkg::clamp_q(div_neg, div_quo);
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          crx_q.y <= cpc_pkg::clamp_q(div_neg, div_quo);
        end
      end
      ST_PUSH_X: begin
        if (can_push) begin
          out_tok_q <= '{pt: crx_q, is_end: 1'b0, last: 1'b0};
        end
      end
      ST_PUSH_E: begin
        if (can_push) begin
          out_tok_q <= '{pt: e_q, is_end: 1'b0, last: 1'b0};
        end
      end
      ST_FWD: begin
        if (can_push) begin
          out_tok_q <= tok_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_vld_o = out_vld_q;
  assign out_tok_o = out_tok_q;

endmodule
`default_nettype wire

>>> src/cpc_out.sv
`default_nettype none
module cpc_out (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           tok_vld_i,
  output logic                tok_rdy_o,
  input  wire cpc_pkg::tok_t  tok_i,
  input  wire logic           rej_i,
  output logic                done_o,
  output logic                res_vld_o,
  input  wire logic           res_rdy_i,
  output cpc_pkg::res_t       res_o
);

  localparam int CW = $clog2(cpc_pkg::OUT_CAP);

  logic          res_vld_q;
  cpc_pkg::res_t res_q;
  cpc_pkg::res_t push_res;
  logic          push;
  logic          can_push;
  logic          hold_vld_q;
  cpc_pkg::pt_t  hold_q;
  logic [CW-1:0] cnt_q;
  logic          room;

  assign can_push  = !res_vld_q || res_rdy_i;
  assign tok_rdy_o = can_push;
  assign room      = cnt_q < CW'(cpc_pkg::OUT_CAP - 1);
  assign done_o    = can_push && ((tok_vld_i && tok_i.is_end) || rej_i);

  // A vertex is held back one request so the final one can carry the last mark.
  always_comb begin
    push     = 1'b0;
    push_res = '{out_x: hold_q.x, out_y: hold_q.y, has_vertex: 1'b1,
                 out_last: 1'b0, rejected: 1'b0};
    if (tok_vld_i && can_push) begin
      if (!tok_i.is_end) begin
        push = hold_vld_q && room;
      end else if (hold_vld_q) begin
        push              = 1'b1;
        push_res.out_last = tok_i.last;
      end else if (tok_i.last) begin
        push     = 1'b1;
        push_res = '{out_x: '0, out_y: '0, has_vertex: 1'b0,
                     out_last: 1'b1, rejected: 1'b0};
      end
    end else if (rej_i && can_push) begin
      push     = 1'b1;
      push_res = '{out_x: '0, out_y: '0, has_vertex: 1'b0,
                   out_last: 1'b1, rejected: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (push) begin
        res_vld_q <= 1'b1;
      end else if (res_rdy_i) begin
        res_vld_q <= 1'b0;
      end
      if (tok_vld_i && can_push) begin
        if (tok_i.is_end) begin
          hold_vld_q <= 1'b0;
          cnt_q      <= '0;
        end else if (!hold_vld_q) begin
          hold_vld_q <= 1'b1;
        end else if (room) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= push_res;
    end
    if (tok_vld_i && can_push && !tok_i.is_end && (!hold_vld_q || room)) begin
      hold_q <= tok_i.pt;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule
`default_nettype wire

>>> src/convex_polygon_clipper.sv
// Channel  | Signals                          | Moves
// ---------+----------------------------------+----------------------------------
// in       | in_valid_i in_ready_o in_data_i  | one subject vertex per request
// out      | out_valid_o out_ready_i out_data_o | one result per request
// cfg      | cfg_we_i cfg_idx_i cfg_data_i    | register write, no wait
//
// An item first runs the clipper corner check (one corner cross product per cycle),
// then walks the row of clipping cells. A cell tests the end and then the start point
// against its edge; for a crossing it forms both line constants, the determinant and both
// numerators, then divides for x and y with its one-bit-per-cycle divider; one item is in flight at a time.
// Reset clears the stage marks and the configuration registers; no clearing pass is needed.
// A stalled output holds the cells back request by request; input waits meanwhile.
`default_nettype none
module convex_polygon_clipper #(
  parameter int MAX_CLIP_EDGES = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire cpc_pkg::vtx_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output cpc_pkg::res_t                       out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [cpc_pkg::IDX_W-1:0]      cfg_idx_i,
  input  wire logic [cpc_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int CB    = cpc_pkg::COORD_BITS;
  localparam int SLOTS = cpc_pkg::CLIP_SLOTS;
  localparam int CNT_W = cpc_pkg::CNT_W;

  typedef enum logic [2:0] {
    T_IDLE, T_CHECK, T_REJ, T_PT, T_END, T_WAIT
  } state_e;

  state_e state_q;
  logic [CNT_W-1:0]          cnt_reg_q;
  logic [cpc_pkg::CFG_W-1:0] pair_q [SLOTS/2];
  cpc_pkg::pt_t              cv [SLOTS];

  cpc_pkg::pt_t   vtx_q;
  logic           last_q;
  logic [CNT_W-1:0] ci_q;
  logic           sgn_seen_q;
  logic           sgn_neg_q;
  logic           bad_q;

  logic             n_ok;
  logic [CNT_W-1:0] nm1;
  logic [CNT_W-1:0] j1, j2;
  logic signed [cpc_pkg::DET_W-1:0] corner;
  logic             check_end;
  logic             seen_clr;

  logic [MAX_CLIP_EDGES:0] ch_vld;
  logic [MAX_CLIP_EDGES:0] ch_rdy;
  cpc_pkg::tok_t           ch_tok [MAX_CLIP_EDGES+1];
  cpc_pkg::edge_t          edges  [MAX_CLIP_EDGES];

  logic out_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_reg_q <= '0;
      for (int i = 0; i < SLOTS / 2; i++) begin
        pair_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpc_pkg::REG_COUNT: cnt_reg_q <= cfg_data_i[CNT_W-1:0];
        cpc_pkg::REG_PAIR0: pair_q[0] <= cfg_data_i;
        cpc_pkg::REG_PAIR1: pair_q[1] <= cfg_data_i;
        cpc_pkg::REG_PAIR2: pair_q[2] <= cfg_data_i;
        cpc_pkg::REG_PAIR3: pair_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cv[i].x = pair_q[i/2][(i%2)*2*CB +: CB];
      cv[i].y = pair_q[i/2][(i%2)*2*CB + CB +: CB];
    end
  end

  assign n_ok = (cnt_reg_q >= CNT_W'(3)) && (32'(cnt_reg_q) <= SLOTS) &&
                (32'(cnt_reg_q) <= MAX_CLIP_EDGES);
  assign nm1  = cnt_reg_q - 1'b1;

  // Corner i of the clipper and its two successors, wrapping at the count.
  always_comb begin
    j1 = ci_q + 1'b1;
    if (j1 >= cnt_reg_q) begin
      j1 = j1 - cnt_reg_q;
    end
    j2 = j1 + 1'b1;
    if (j2 >= cnt_reg_q) begin
      j2 = j2 - cnt_reg_q;
    end
    corner = cpc_pkg::cross3(cv[ci_q[2:0]], cv[j1[2:0]], cv[j2[2:0]]);
  end

  assign check_end = (state_q == T_CHECK) && (bad_q || (ci_q == cnt_reg_q));
  assign seen_clr  = check_end && bad_q && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      ci_q       <= '0;
      sgn_seen_q <= 1'b0;
      sgn_neg_q  <= 1'b0;
      bad_q      <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      case (state_q)
        T_IDLE: begin
          if (in_valid_i) begin
            last_q     <= in_data_i.vertex_last;
            ci_q       <= '0;
            sgn_seen_q <= 1'b0;
            sgn_neg_q  <= 1'b0;
            bad_q      <= !n_ok;
            state_q    <= T_CHECK;
          end
        end
        T_CHECK: begin
          if (check_end) begin
            if (!bad_q) begin
              state_q <= T_PT;
            end else begin
              state_q <= last_q ? T_REJ : T_IDLE;
            end
          end else begin
            ci_q <= ci_q + 1'b1;
            if (corner != '0) begin
              if (!sgn_seen_q) begin
                sgn_seen_q <= 1'b1;
                sgn_neg_q  <= corner[cpc_pkg::DET_W-1];
              end else if (sgn_neg_q != corner[cpc_pkg::DET_W-1]) begin
                bad_q <= 1'b1;
              end
            end
          end
        end
        T_REJ: begin
          if (out_done) begin
            state_q <= T_IDLE;
          end
        end
        T_PT: begin
          if (ch_rdy[0]) begin
            state_q <= T_END;
          end
        end
        T_END: begin
          if (ch_rdy[0]) begin
            state_q <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (out_done) begin
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == T_IDLE) && in_valid_i) begin
      vtx_q <= '{x: in_data_i.vertex_x, y: in_data_i.vertex_y};
    end
  end

  assign in_ready_o = (state_q == T_IDLE);

  assign ch_vld[0] = (state_q == T_PT) || (state_q == T_END);
  assign ch_tok[0] = '{pt: vtx_q, is_end: (state_q == T_END), last: last_q};

  for (genvar k = 0; k < MAX_CLIP_EDGES; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign edges[k] = '{b: cv[nm1[2:0]], f: cv[k], en: (cnt_reg_q > CNT_W'(k))};
    end else if (k < SLOTS) begin : g_mid
      assign edges[k] = '{b: cv[k-1], f: cv[k], en: (cnt_reg_q > CNT_W'(k))};
    end else begin : g_off
      assign edges[k] = '0;
    end

    cpc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .edge_i    (edges[k]),
      .clear_i   (seen_clr),
      .in_vld_i  (ch_vld[k]),
      .in_rdy_o  (ch_rdy[k]),
      .in_tok_i  (ch_tok[k]),
      .out_vld_o (ch_vld[k+1]),
      .out_rdy_i (ch_rdy[k+1]),
      .out_tok_o (ch_tok[k+1])
    );
  end

  cpc_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_vld_i (ch_vld[MAX_CLIP_EDGES]),
    .tok_rdy_o (ch_rdy[MAX_CLIP_EDGES]),
    .tok_i     (ch_tok[MAX_CLIP_EDGES]),
    .rej_i     (state_q == T_REJ),
    .done_o    (out_done),
    .res_vld_o (out_valid_o),
    .res_rdy_i (out_ready_i),
    .res_o     (out_data_o)
  );

  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rejected |-> out_data_o.out_last)
    else $error("rejected result without last mark");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_vertex |->
      out_data_o.out_last && (out_data_o.out_x == '0) && (out_data_o.out_y == '0))
    else $error("vertexless result malformed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_clr |-> !ch_vld[0])
    else $error("stage clear while cells busy");

endmodule
`default_nettype wire

>>> dv/convex_polygon_clipper_test.sv
`default_nettype none
module convex_polygon_clipper_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint x;
    longint y;
  } ipt_t;

  class clip_scoreboard;
    logic [3:0]  clip_count;
    logic [47:0] clip_pairs[4];
    ipt_t        first_pt[8];
    ipt_t        prev_pt[8];
    bit          seen[8];
    cpc_pkg::res_t pending_q[$];
    int          errors;

    function void clear_state();
      clip_count = '0;
      foreach (clip_pairs[i]) clip_pairs[i] = '0;
      foreach (seen[i]) seen[i] = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(cpc_pkg::reg_idx_e idx, logic [47:0] val);
      if (idx == cpc_pkg::REG_COUNT) clip_count = val[3:0];
      else clip_pairs[int'(idx) - 1] = val;
    endfunction

    function ipt_t corner(int i);
      ipt_t v;
      logic [47:0] r;
      r = clip_pairs[i / 2];
      if (i % 2) begin
        v.x = r[35:24];
        v.y = r[47:36];
      end else begin
        v.x = r[11:0];
        v.y = r[23:12];
      end
      return v;
    endfunction

    function longint side_of(ipt_t p, ipt_t b, ipt_t e);
      return (p.x - b.x) * (e.y - b.y) - (p.y - b.y) * (e.x - b.x);
    endfunction

    function longint clamp(longint v);
      return v < 0 ? 0 : (v > cpc_pkg::COORD_MAX ? cpc_pkg::COORD_MAX : v);
    endfunction

    function ipt_t meet(ipt_t b1, ipt_t e1, ipt_t b2, ipt_t e2);
      ipt_t r;
      longint a1, c1, k1, a2, c2, k2, dt;
      a1 = e1.y - b1.y; c1 = b1.x - e1.x; k1 = a1 * b1.x + c1 * b1.y;
      a2 = e2.y - b2.y; c2 = b2.x - e2.x; k2 = a2 * b2.x + c2 * b2.y;
      dt = a1 * c2 - a2 * c1;
      r.x = 0;
      r.y = 0;
      if (dt != 0) begin
        r.x = clamp((c2 * k1 - c1 * k2) / dt);
        r.y = clamp((a1 * k2 - a2 * k1) / dt);
      end
      return r;
    endfunction

    function void push_pt(ref ipt_t l[$], input ipt_t p);
      if (l.size() < 64) l.insert(l.size(), p);
    endfunction

    function void clip_seg(ipt_t s, ipt_t e, ipt_t b, ipt_t f, ref ipt_t o[$]);
      bit e_in, s_in;
      e_in = side_of(e, b, f) >= 0;
      s_in = side_of(s, b, f) >= 0;
      if (e_in) begin
        if (!s_in) push_pt(o, meet(s, e, b, f));
        push_pt(o, e);
      end else if (s_in) begin
        push_pt(o, meet(s, e, b, f));
      end
    endfunction

    // Expected results for one accepted vertex.
    function void note_vertex(cpc_pkg::vtx_in_t v);
      ipt_t cv[8];
      ipt_t cur[$];
      ipt_t nxt[$];
      ipt_t p, a, b, c;
      cpc_pkg::res_t r;
      int n, sgn, cs, total;
      bit ok;
      longint cr;
      n = clip_count;
      ok = n >= 3 && n <= 8;
      if (ok) begin
        for (int i = 0; i < n; i++) cv[i] = corner(i);
        sgn = 0;
        for (int i = 0; i < n; i++) begin
          a = cv[i]; b = cv[(i + 1) % n]; c = cv[(i + 2) % n];
          cr = (b.x - a.x) * (c.y - b.y) - (b.y - a.y) * (c.x - b.x);
          if (cr != 0) begin
            cs = cr > 0 ? 1 : -1;
            if (sgn == 0) sgn = cs;
            else if (sgn != cs) ok = 0;
          end
        end
      end
      if (!ok) begin
        if (!v.vertex_last) return;
        foreach (seen[i]) seen[i] = 1'b0;
        r = '0;
        r.out_last = 1'b1;
        r.rejected = 1'b1;
        pending_q.insert(pending_q.size(), r);
        return;
      end
      p.x = v.vertex_x;
      p.y = v.vertex_y;
      cur.insert(cur.size(), p);
      for (int k = 0; k < n; k++) begin
        b = cv[(k + n - 1) % n];
        c = cv[k];
        nxt.delete();
        foreach (cur[i]) begin
          if (!seen[k]) begin
            first_pt[k] = cur[i];
            seen[k] = 1'b1;
          end else begin
            clip_seg(prev_pt[k], cur[i], b, c, nxt);
          end
          prev_pt[k] = cur[i];
        end
        if (v.vertex_last && seen[k]) begin
          clip_seg(prev_pt[k], first_pt[k], b, c, nxt);
          seen[k] = 1'b0;
        end
        cur = nxt;
      end
      total = cur.size() < cpc_pkg::OUT_CAP ? cur.size() : cpc_pkg::OUT_CAP;
      for (int i = 0; i < total; i++) begin
        r = '0;
        r.out_x = 12'(cur[i].x);
        r.out_y = 12'(cur[i].y);
        r.has_vertex = 1'b1;
        r.out_last = v.vertex_last && i == total - 1;
        pending_q.insert(pending_q.size(), r);
      end
      if (v.vertex_last && total == 0) begin
        r = '0;
        r.out_last = 1'b1;
        pending_q.insert(pending_q.size(), r);
      end
    endfunction

    function void check_result(cpc_pkg::res_t act);
      cpc_pkg::res_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, act);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (act.out_x !== exp_r.out_x || act.out_y !== exp_r.out_y ||
          act.has_vertex !== exp_r.has_vertex || act.out_last !== exp_r.out_last ||
          act.rejected !== exp_r.rejected) begin
        $display("%0t: result mismatch, expected %p, actual %p", $realtime, exp_r, act);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  cpc_pkg::vtx_in_t in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  cpc_pkg::res_t out_data_o;
  logic        cfg_we_i;
  logic [cpc_pkg::IDX_W-1:0] cfg_idx_i;
  logic [cpc_pkg::CFG_W-1:0] cfg_data_i;

  clip_scoreboard sb;
  int burst_left;
  int hold_left;
  int sent_items;
  int stall_mode;

  convex_polygon_clipper u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: stalls in random stretches, always ready in others, long hold on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_mode == 0) begin
        out_ready_i <= 1'b1;
      end else if (stall_mode == 1) begin
        out_ready_i <= $urandom_range(0, 3) != 0;
      end else begin
        out_ready_i <= $urandom_range(0, 3) == 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic write_reg(cpc_pkg::reg_idx_e idx, logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  function automatic logic [23:0] pack_pt(ipt_t p);
    return {p.y[11:0], p.x[11:0]};
  endfunction

  task automatic load_clipper(int n, ipt_t pts[8]);
    logic [47:0] cnt_word;
    cnt_word = 48'({$urandom, $urandom});
    cnt_word[3:0] = 4'(n);
    write_reg(cpc_pkg::REG_COUNT, cnt_word);
    write_reg(cpc_pkg::REG_PAIR0, {pack_pt(pts[1]), pack_pt(pts[0])});
    write_reg(cpc_pkg::REG_PAIR1, {pack_pt(pts[3]), pack_pt(pts[2])});
    write_reg(cpc_pkg::REG_PAIR2, {pack_pt(pts[5]), pack_pt(pts[4])});
    write_reg(cpc_pkg::REG_PAIR3, {pack_pt(pts[7]), pack_pt(pts[6])});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_vertex(longint x, longint y, bit last);
    in_valid_i <= 1'b1;
    in_data_i  <= '{vertex_x: 12'(x), vertex_y: 12'(y), vertex_last: last};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_vertex('{vertex_x: 12'(x), vertex_y: 12'(y), vertex_last: last});
    sent_items++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  // Wait for every expected result, then let non-emitting items finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2500) @(posedge clk_i);
  endtask

  task automatic send_poly(ipt_t poly[$]);
    foreach (poly[i]) send_vertex(poly[i].x, poly[i].y, i == poly.size() - 1);
  endtask

  // Convex clipper: subset of an octagon around a random center, either winding.
  task automatic random_convex(int n, output ipt_t pts[8]);
    int dirx[8] = '{10, 7, 0, -7, -10, -7, 0, 7};
    int diry[8] = '{0, 7, 10, 7, 0, -7, -10, -7};
    int keep[$];
    longint cx, cy, rad;
    ipt_t t;
    rad = $urandom_range(10, 200);
    cx  = $urandom_range(rad, 4095 - rad);
    cy  = $urandom_range(rad, 4095 - rad);
    for (int i = 0; i < 8; i++) keep.insert(keep.size(), i);
    while (keep.size() > n) keep.delete($urandom_range(0, keep.size() - 1));
    foreach (pts[i]) pts[i] = '{0, 0};
    foreach (keep[i]) begin
      pts[i].x = cx + dirx[keep[i]] * rad / 10;
      pts[i].y = cy + diry[keep[i]] * rad / 10;
    end
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < n / 2; i++) begin
        t = pts[i];
        pts[i] = pts[n - 1 - i];
        pts[n - 1 - i] = t;
      end
    end
  endtask

  function automatic ipt_t rand_pt(bit wide);
    ipt_t p;
    if (wide) begin
      p.x = $urandom_range(0, 4095);
      p.y = $urandom_range(0, 4095);
    end else begin
      p.x = $urandom_range(1400, 2700);
      p.y = $urandom_range(1400, 2700);
    end
    return p;
  endfunction

  initial begin
    ipt_t clip[8];
    ipt_t poly[$];
    int n, len;
    bit wide;
    sb = new();
    sb.clear_state();
    hold_left   = 0;
    burst_left  = 4;
    sent_items  = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: count zero rejects.
    poly = '{'{0, 0}, '{4095, 4095}, '{17, 3000}};
    send_poly(poly);
    drain();

    // Square covering the middle, counterclockwise.
    clip = '{'{1000, 1000}, '{3000, 1000}, '{3000, 3000}, '{1000, 3000},
             '{0, 0}, '{0, 0}, '{0, 0}, '{0, 0}};
    load_clipper(4, clip);
    poly = '{'{0, 0}, '{4095, 0}, '{4095, 4095}, '{0, 4095}};
    send_poly(poly);
    poly = '{'{2000, 2000}};
    send_poly(poly);
    poly = '{'{1500, 1500}, '{2500, 1500}, '{2000, 2500}};
    send_poly(poly);
    poly = '{'{10, 10}, '{200, 10}, '{100, 300}};
    send_poly(poly);
    poly = '{'{0, 2000}, '{4095, 2001}};
    send_poly(poly);
    drain();
    // Same square, other winding.
    clip = '{'{1000, 3000}, '{3000, 3000}, '{3000, 1000}, '{1000, 1000},
             '{0, 0}, '{0, 0}, '{0, 0}, '{0, 0}};
    load_clipper(4, clip);
    poly = '{'{0, 0}, '{4095, 0}, '{4095, 4095}, '{0, 4095}};
    send_poly(poly);
    drain();
    // Full-range octagon-ish clipper with eight corners at the extremes.
    clip = '{'{0, 2047}, '{1200, 0}, '{2900, 0}, '{4095, 1200},
             '{4095, 2900}, '{2900, 4095}, '{1200, 4095}, '{0, 2900}};
    load_clipper(8, clip);
    poly = '{'{0, 0}, '{4095, 0}, '{4095, 4095}, '{0, 4095}};
    send_poly(poly);
    drain();
    // Count above eight, and a concave clipper: both reject.
    load_clipper(15, clip);
    poly = '{'{5, 5}, '{6, 7}};
    send_poly(poly);
    drain();
    clip = '{'{1000, 1000}, '{3000, 1000}, '{2000, 1500}, '{2000, 3000},
             '{0, 0}, '{0, 0}, '{0, 0}, '{0, 0}};
    load_clipper(4, clip);
    poly = '{'{2000, 2000}, '{2100, 2000}};
    send_poly(poly);
    drain();

    for (int phase = 0; sent_items < 260; phase++) begin
      n = $urandom_range(3, 8);
      random_convex(n, clip);
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 2);
        1: n = $urandom_range(9, 15);
        2: foreach (clip[i]) clip[i] = rand_pt(1'b1);
        default: ;
      endcase
      load_clipper(n, clip);
      if (phase == 2) hold_left = 800;
      for (int p = 0; p < 5; p++) begin
        len = $urandom_range(0, 9) == 0 ? $urandom_range(12, 18) : $urandom_range(1, 7);
        wide = $urandom_range(0, 3) == 0;
        poly.delete();
        for (int i = 0; i < len; i++) begin
          if (wide) begin
            poly.insert(poly.size(), rand_pt(1'b1));
          end else begin
            poly.insert(poly.size(), '{clip[0].x + $urandom_range(0, 600) - 300,
                                       clip[0].y + $urandom_range(0, 600) - 300});
            poly[i].x = poly[i].x < 0 ? 0 : (poly[i].x > 4095 ? 4095 : poly[i].x);
            poly[i].y = poly[i].y < 0 ? 0 : (poly[i].y > 4095 ? 4095 : poly[i].y);
          end
        end
        send_poly(poly);
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> convex_polygon_clipper.f
src/cpc_pkg.sv
src/cpc_div.sv
src/cpc_cell.sv
src/cpc_out.sv
src/convex_polygon_clipper.sv
dv/convex_polygon_clipper_test.sv
